// ===== sv/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg: shared types for the top-k score table
// Record layout, command and status codes, and the control word that the
// table controller hands to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Result status carried in m_tuser.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_ID     = 2'd1,
        STATUS_NOT_FILLED = 2'd2
    } status_t;

    // One score record as held in a cell.
    typedef struct packed {
        logic [23:0]        initials;
        logic [3:0]         outcome;
        logic [31:0]        moves;
        logic signed [31:0] points;
        logic [26:0]        date;
        logic [31:0]        id;
    } record_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic insert;   // sorted insertion of the broadcast record
        logic rotate;   // every cell takes its right neighbor's record
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tks_cell.sv =====
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted score chain
// Holds one record. On an insertion it keeps its record, takes the new one,
// or takes its left neighbor's record; on a rotation it takes its right
// neighbor's record.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_cell (
    input  wire logic               clk,
    input  wire tks_pkg::cell_ctl_t ctl,
    input  wire tks_pkg::record_t   new_rec,
    input  wire tks_pkg::record_t   prev_rec,
    input  wire tks_pkg::record_t   next_rec,
    input  wire logic               prev_keep,
    input  wire logic               filled,
    output tks_pkg::record_t        rec,
    output logic                    keep
);

    tks_pkg::record_t rec_reg;
    tks_pkg::record_t rec_next;

    // A filled slot whose score is equal or higher stays ahead of the new record.
    assign keep = filled && !($signed(rec_reg.points) < $signed(new_rec.points));
    assign rec  = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.insert)
        begin
            if (!keep)
            begin
                rec_next = prev_keep ? new_rec : prev_rec;
            end
        end
        else if (ctl.rotate)
        begin
            rec_next = next_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

// ===== sv/top_k_score_table.sv =====
// ----------------------------------------------------------------------------
// top_k_score_table: bounded table of score records in descending order
// A chain of record cells kept sorted by signed score, with add, read and
// clear requests on a stream interface.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells, cell 0 holding the highest score.
// An add request with a nonzero id is inserted in parallel: every cell
// compares its own score with the new one at once, cells ahead of the
// insertion point hold, the cell at the insertion point takes the new record
// and the cells behind it take their left neighbor's record, so the lowest
// record falls off the end when the table is full. Equal scores keep their
// order of arrival. A clear, a rejected add, an unknown command and a read of
// an unfilled position need no rotation; their result goes straight into the
// result register. A read of a filled position rotates the whole chain once
// around, one cell per cycle, and catches the wanted record as it passes
// cell 0 into the result register; the table is back in place at the end.
// Requests are taken only in the idle state while the result register is
// empty or being emptied, so one request is at work at a time. Record fields
// of every result other than a successful read are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tuser: cmd[1:0]
    input  wire logic [1:0]   s_tuser,
    // s_tdata: slot_index[3:0], record_id[35:4], packed_date[62:36],
    //          points[94:63], move_total[126:95], outcome[130:127],
    //          initials[154:131], zero fill[159:155]
    input  wire logic [159:0] s_tdata,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tuser: status[1:0]
    output logic [1:0]        m_tuser,
    // m_tdata: entries_held[4:0], out_id[36:5], out_date[63:37],
    //          out_points[95:64], out_moves[127:96], out_outcome[131:128],
    //          out_initials[155:132], zero fill[159:156]
    output logic [159:0]      m_tdata
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TABLE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_ROTATE
    } state_t;

    state_t state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    tks_pkg::status_t out_status_reg, out_status_next;
    logic [4:0]    out_held_reg, out_held_next;
    tks_pkg::record_t out_rec_reg, out_rec_next;

    // Request fields.
    tks_pkg::cmd_t    in_cmd;
    logic [3:0]       in_idx;
    tks_pkg::record_t in_rec;
    logic             accept;
    logic [CW-1:0]    kept;

    tks_pkg::cell_ctl_t ctl;
    tks_pkg::record_t   cell_rec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_keep;

    assign in_cmd          = tks_pkg::cmd_t'(s_tuser);
    assign in_idx          = s_tdata[3:0];
    assign in_rec.id       = s_tdata[35:4];
    assign in_rec.date     = s_tdata[62:36];
    assign in_rec.points   = s_tdata[94:63];
    assign in_rec.moves    = s_tdata[126:95];
    assign in_rec.outcome  = s_tdata[130:127];
    assign in_rec.initials = s_tdata[154:131];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Records that survive an add: a full table gives up its last slot.
    assign kept = (count_reg >= CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH - 1) : count_reg;

    // The cell chain. Cell 0 sees "keep" on its left so it takes the new
    // record whenever it does not hold its own; the last cell wraps to cell 0
    // for rotation.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        tks_pkg::record_t prev_rec;
        logic             prev_keep;

        if (i == 0)
        begin : g_head
            assign prev_rec  = in_rec;
            assign prev_keep = 1'b1;
        end
        else
        begin : g_body
            assign prev_rec  = cell_rec[i-1];
            assign prev_keep = cell_keep[i-1];
        end

        tks_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .new_rec   (in_rec),
            .prev_rec  (prev_rec),
            .next_rec  (cell_rec[(i + 1) % TABLE_DEPTH]),
            .prev_keep (prev_keep),
            .filled    (CW'(i) < kept),
            .rec       (cell_rec[i]),
            .keep      (cell_keep[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_held_next   = out_held_reg;
        out_rec_next    = out_rec_reg;
        ctl             = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_rec_next    = '0;
                    out_status_next = tks_pkg::STATUS_OK;
                    out_valid_next  = 1'b1;
                    unique case (in_cmd)
                        tks_pkg::CMD_ADD:
                        begin
                            if (in_rec.id == 32'd0)
                            begin
                                out_status_next = tks_pkg::STATUS_BAD_ID;
                            end
                            else
                            begin
                                ctl.insert = 1'b1;
                                count_next = kept + CW'(1);
                            end
                        end
                        tks_pkg::CMD_READ:
                        begin
                            if (32'(in_idx) >= 32'(count_reg))
                            begin
                                out_status_next = tks_pkg::STATUS_NOT_FILLED;
                            end
                            else
                            begin
                                // The result goes out when the rotation ends.
                                out_valid_next = 1'b0;
                                state_next     = ST_ROTATE;
                                step_next      = '0;
                                idx_next       = in_idx;
                            end
                        end
                        tks_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // Unused command code: acknowledged, no effect.
                        end
                    endcase
                    out_held_next = 5'(count_next);
                end
            end
            ST_ROTATE:
            begin
                ctl.rotate = 1'b1;
                // After step_reg rotations cell 0 holds original slot step_reg.
                if (32'(step_reg) == 32'(idx_reg))
                begin
                    out_rec_next = cell_rec[0];
                end
                if (step_reg == SW'(TABLE_DEPTH - 1))
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                else
                begin
                    step_next = step_reg + SW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= tks_pkg::STATUS_OK;
            out_held_reg   <= '0;
            out_rec_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_held_reg   <= out_held_next;
            out_rec_reg    <= out_rec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_rec_reg.initials, out_rec_reg.outcome, out_rec_reg.moves,
                       out_rec_reg.points, out_rec_reg.date, out_rec_reg.id, out_held_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("record count exceeds table depth");

    a_bad_id_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == tks_pkg::CMD_ADD && in_rec.id == 32'd0)
        |=> (m_tvalid && m_tuser == tks_pkg::STATUS_BAD_ID && count_reg == $past(count_reg)))
        else $error("rejected add did not report or changed the table");

    a_read_starts_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == tks_pkg::CMD_READ && 32'(in_idx) < 32'(count_reg))
        |=> (!m_tvalid && state_reg == ST_ROTATE && step_reg == '0))
        else $error("read of a filled slot did not start a rotation");

    a_rotation_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && step_reg == SW'(TABLE_DEPTH - 1))
        |=> (state_reg == ST_IDLE && m_tvalid && m_tuser == tks_pkg::STATUS_OK))
        else $error("rotation did not end with a read result");

    a_no_accept_in_rotation: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE) |-> (!s_tready && !m_tvalid && count_reg == $past(count_reg)))
        else $error("request taken or table changed during rotation");
`endif

endmodule

`default_nettype wire
